[hw/rtl/csrspmv_pkg.sv]
// Shared types and constants for the CSR sparse matrix-vector multiply block.
`default_nettype none

package csrspmv_pkg;

  localparam int COL_W = 15;
  localparam int VALUE_W = 32;
  localparam int SUM_W = 64;
  localparam int VECTOR_LENGTH_DEFAULT = 32768;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ENTRY = 2'd1,
    REQ_EMPTY = 2'd2
  } req_kind_t;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [COL_W-1:0]          column;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      last_in_row;
  } req_t;

  typedef struct packed {
    logic [COL_W-1:0]        row_index;
    logic signed [SUM_W-1:0] row_sum;
  } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/csrspmv_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module csrspmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/csr_sparse_matrix_vector_multiply.sv]
// Top level of the CSR sparse matrix-vector multiply with its vector memory and MAC pipeline.
// A row result is registered in stage 1, stage 2 and the output register after the row closes.
// Throughput: one transaction per cycle unless a closed row waits on a full output register,
// set by a registered memory read, one 32 x 32 multiply stage, one 64-bit accumulate stage.
// Reset clears the pipeline and output valid flags, the row sum and the row counter.
// The vector memory is not cleared; elements are defined once written by a load.
`default_nettype none

module csr_sparse_matrix_vector_multiply #(
  parameter int VECTOR_LENGTH = csrspmv_pkg::VECTOR_LENGTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire csrspmv_pkg::req_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output csrspmv_pkg::rsp_t      rsp
);

  localparam int ADDR_W = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int EXT_W = (ADDR_W > csrspmv_pkg::COL_W) ? ADDR_W : csrspmv_pkg::COL_W;

  logic                                    accept;
  logic                                    advance;
  logic                                    out_load;
  logic                                    is_load;
  logic                                    is_entry;
  logic                                    is_empty;
  logic                                    in_range;
  logic [EXT_W-1:0]                        col_ext;
  logic [ADDR_W-1:0]                       addr;
  logic [csrspmv_pkg::VALUE_W-1:0]         rdata;
  logic signed [csrspmv_pkg::VALUE_W-1:0]  elem;
  logic signed [csrspmv_pkg::SUM_W-1:0]    product;
  logic signed [csrspmv_pkg::SUM_W-1:0]    sum_next;

  logic                                    s1_valid;
  logic                                    s1_empty;
  logic                                    s1_last;
  logic                                    s1_in_range;
  logic signed [csrspmv_pkg::VALUE_W-1:0]  s1_value;

  logic                                    s2_valid;
  logic                                    s2_empty;
  logic                                    s2_last;
  logic signed [csrspmv_pkg::SUM_W-1:0]    s2_prod;

  logic signed [csrspmv_pkg::SUM_W-1:0]    row_acc;
  logic [csrspmv_pkg::COL_W-1:0]           row_count;

  always_comb begin
    is_load  = 1'b0;
    is_entry = 1'b0;
    is_empty = 1'b0;
    case (req.req_type)
      csrspmv_pkg::REQ_LOAD:  is_load  = 1'b1;
      csrspmv_pkg::REQ_ENTRY: is_entry = 1'b1;
      csrspmv_pkg::REQ_EMPTY: is_empty = 1'b1;
      default: begin
        is_load  = 1'b0;
        is_entry = 1'b0;
        is_empty = 1'b0;
      end
    endcase
  end

  assign col_ext  = EXT_W'(req.column);
  assign addr     = col_ext[ADDR_W-1:0];
  assign in_range = 32'(req.column) < 32'(VECTOR_LENGTH);

  assign advance   = !(s2_valid && (s2_empty || s2_last) && rsp_valid && !rsp_ready);
  assign req_ready = advance;
  assign accept    = req_valid && req_ready;
  assign out_load  = advance && s2_valid && (s2_empty || s2_last);

  csrspmv_ram #(
    .WIDTH (csrspmv_pkg::VALUE_W),
    .DEPTH (VECTOR_LENGTH)
  ) u_vector_ram (
    .clk   (clk),
    .we    (accept && is_load && in_range),
    .waddr (addr),
    .wdata (req.entry_value),
    .re    (advance),
    .raddr (addr),
    .rdata (rdata)
  );

  assign elem     = s1_in_range ? $signed(rdata) : '0;
  assign product  = s1_value * elem;
  assign sum_next = row_acc + s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      row_acc   <= '0;
      row_count <= '0;
    end else begin
      if (advance) begin
        s1_valid <= accept && (is_entry || is_empty);
        s2_valid <= s1_valid;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (advance && s2_valid) begin
        if (s2_empty) begin
          row_count <= row_count + 1'b1;
        end else if (s2_last) begin
          row_acc   <= '0;
          row_count <= row_count + 1'b1;
        end else begin
          row_acc <= sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_empty    <= is_empty;
      s1_last     <= req.last_in_row;
      s1_in_range <= in_range;
      s1_value    <= req.entry_value;
      s2_empty    <= s1_empty;
      s2_last     <= s1_last;
      s2_prod     <= product;
    end
    if (out_load) begin
      rsp.row_index <= row_count;
      rsp.row_sum   <= s2_empty ? '0 : sum_next;
    end
  end

  a_ready_when_output_free: assert property (
    @(posedge clk) disable iff (rst) !rsp_valid |-> req_ready
  ) else $error("Input stalled although the output register is free.");

  a_no_result_overwrite: assert property (
    @(posedge clk) disable iff (rst) out_load |-> (!rsp_valid || rsp_ready)
  ) else $error("A pending result would be overwritten.");

  a_row_count_steps: assert property (
    @(posedge clk) disable iff (rst)
    out_load |=> row_count == $past(row_count) + 1'b1
  ) else $error("Row counter did not advance with an emitted row.");

  a_sum_cleared: assert property (
    @(posedge clk) disable iff (rst)
    (out_load && !s2_empty) |=> row_acc == '0
  ) else $error("Row sum not cleared after the last entry of a row.");

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the CSR sparse matrix-vector multiply block.
module tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int VEC_DEPTH = 32768;
  localparam int RANDOM_ITEMS = 1030;
  localparam int EMPTY_BURST = 100;
  localparam int LONG_HOLD_AT = 50;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef struct {
    csrspmv_pkg::req_t item;
    int unsigned       gap;
    bit                drain;
  } pending_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  csrspmv_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  csrspmv_pkg::rsp_t rsp;

  pending_req_t pending_reqs[$];
  csrspmv_pkg::rsp_t row_results_q[$];
  logic [31:0] vec_mirror [0:VEC_DEPTH-1];
  logic [63:0] row_sum_acc = '0;
  logic [14:0] next_row = '0;
  int unsigned rows_predicted = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_calm = 0;
  bit long_hold_done = 1'b0;
  int unsigned gen_calm = 0;
  bit gen_drain = 1'b0;
  int unsigned gen_count = 0;
  logic [14:0] gen_cols[$];

  csr_sparse_matrix_vector_multiply dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return VAL_MIN;
    if (r == 1) return VAL_MAX;
    if (r == 2) return $urandom_range(0, 8) - 32'd4;
    return $urandom();
  endfunction

  function automatic void push_item(logic [1:0] kind, logic [14:0] col, logic [31:0] val,
                                    logic last);
    pending_req_t p;
    p.item.req_type = kind;
    p.item.column = col;
    p.item.entry_value = val;
    p.item.last_in_row = last;
    p.drain = gen_drain;
    gen_drain = 1'b0;
    if (gen_calm > 0) begin
      p.gap = 0;
      gen_calm--;
    end else begin
      p.gap = pick_gap();
      if ($urandom_range(0, 49) == 0) gen_calm = 40;
    end
    pending_reqs.push_back(p);
    if (kind != REQ_UNUSED) gen_count++;
    if (kind == csrspmv_pkg::REQ_LOAD) gen_cols.push_back(col);
  endfunction

  function automatic logic [14:0] loaded_col();
    return gen_cols[$urandom_range(0, gen_cols.size() - 1)];
  endfunction

  function automatic void emit_row(logic [63:0] sum);
    csrspmv_pkg::rsp_t row;
    row.row_index = next_row;
    row.row_sum = sum;
    row_results_q.push_back(row);
    next_row++;
    rows_predicted++;
  endfunction

  function automatic void apply_spmv_request(csrspmv_pkg::req_t r);
    longint prod;
    case (r.req_type)
      csrspmv_pkg::REQ_LOAD: vec_mirror[r.column] = r.entry_value;
      csrspmv_pkg::REQ_ENTRY: begin
        prod = longint'($signed(r.entry_value)) * longint'($signed(vec_mirror[r.column]));
        row_sum_acc += prod;
        if (r.last_in_row) begin
          emit_row(row_sum_acc);
          row_sum_acc = '0;
        end
      end
      csrspmv_pkg::REQ_EMPTY: emit_row('0);
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else begin
      if (req_valid && req_ready) apply_spmv_request(req);
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() == 0) begin
          req_valid <= 1'b0;
        end else if (pending_reqs[0].gap > 0) begin
          pending_reqs[0].gap = pending_reqs[0].gap - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs[0].drain && rows_predicted != results_seen) begin
          req_valid <= 1'b0;
        end else begin
          req <= pending_reqs[0].item;
          req_valid <= 1'b1;
          void'(pending_reqs.pop_front());
        end
      end
    end
  end

  // The single long hold-off falls while the sender streams empty rows back to back.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        rx_stall = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        if (rx_calm > 0) rx_calm--;
        else if ($urandom_range(0, 199) == 0) rx_calm = 300;
        else if ($urandom_range(0, 9) == 0) rx_stall = 1 + pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    csrspmv_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen <= results_seen + 1;
      if (row_results_q.size() == 0) begin
        note_mismatch($sformatf("unexpected row result: row %0d sum %0d",
                                rsp.row_index, rsp.row_sum));
      end else begin
        want = row_results_q.pop_front();
        if (rsp.row_index !== want.row_index || rsp.row_sum !== want.row_sum)
          note_mismatch($sformatf("row result mismatch: expected row %0d sum %0d, got row %0d sum %0d",
                                  want.row_index, want.row_sum, rsp.row_index, rsp.row_sum));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned k;

    push_item(csrspmv_pkg::REQ_LOAD, 15'd0, VAL_MIN, 1'b1);
    push_item(csrspmv_pkg::REQ_LOAD, 15'h7FFF, VAL_MAX, 1'b0);
    push_item(csrspmv_pkg::REQ_LOAD, 15'd1, 32'hFFFF_FFFF, 1'b0);
    push_item(csrspmv_pkg::REQ_LOAD, 15'h5555, 32'h1234_5678, 1'b1);
    push_item(REQ_UNUSED, 15'h2AAA, 32'hDEAD_BEEF, 1'b1);
    push_item(csrspmv_pkg::REQ_EMPTY, 15'h7FFF, VAL_MAX, 1'b0);
    // Four products of two's complement extremes push the row sum past 2^63, out of signed 64-bit range.
    repeat (3) push_item(csrspmv_pkg::REQ_ENTRY, 15'd0, VAL_MIN, 1'b0);
    push_item(csrspmv_pkg::REQ_ENTRY, 15'h7FFF, VAL_MAX, 1'b1);
    push_item(csrspmv_pkg::REQ_ENTRY, 15'h7FFF, VAL_MIN, 1'b1);
    push_item(csrspmv_pkg::REQ_ENTRY, 15'd1, 32'd5, 1'b0);
    push_item(csrspmv_pkg::REQ_EMPTY, 15'd0, 32'd0, 1'b1);
    push_item(csrspmv_pkg::REQ_ENTRY, 15'd1, VAL_MAX, 1'b1);
    push_item(csrspmv_pkg::REQ_ENTRY, 15'h5555, 32'd3, 1'b1);
    push_item(REQ_UNUSED, 15'h5555, VAL_MIN, 1'b0);
    push_item(csrspmv_pkg::REQ_EMPTY, 15'h2AAA, 32'hFFFF_FFFF, 1'b1);

    gen_drain = 1'b1;
    gen_calm = EMPTY_BURST;
    repeat (EMPTY_BURST)
      push_item(csrspmv_pkg::REQ_EMPTY, 15'($urandom()), $urandom(), 1'($urandom()));

    gen_drain = 1'b1;
    gen_count = 0;
    while (gen_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        repeat ($urandom_range(1, 8))
          push_item(csrspmv_pkg::REQ_LOAD, 15'($urandom()), rand_value(), 1'($urandom()));
      end else if (pick < 72) begin
        k = $urandom_range(1, 6);
        for (int i = 1; i <= k; i++)
          push_item(csrspmv_pkg::REQ_ENTRY, loaded_col(), rand_value(), i == k);
      end else if (pick < 84) begin
        push_item(csrspmv_pkg::REQ_EMPTY, 15'($urandom()), $urandom(), 1'($urandom()));
      end else if (pick < 93) begin
        k = $urandom_range(1, 3);
        repeat (k) push_item(csrspmv_pkg::REQ_ENTRY, loaded_col(), rand_value(), 1'b0);
        push_item(csrspmv_pkg::REQ_EMPTY, 15'($urandom()), $urandom(), 1'($urandom()));
      end else begin
        push_item(REQ_UNUSED, 15'($urandom()), $urandom(), 1'($urandom()));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || req_valid || rows_predicted != results_seen)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
